>>> src/mal_pkg.sv
// ----------------------------------------------------------------------------
// mal_pkg: shared types and codes for the most-recent-first application list
// Entry layout of the list memory and the operation codes.
// ----------------------------------------------------------------------------
package mal_pkg;

  // One list entry: foreground mark and application key.
  typedef struct packed {
    logic       fg;
    logic [7:0] key;
  } entry_t;

  localparam logic [2:0] OP_LAUNCH  = 3'd0;
  localparam logic [2:0] OP_SUSPEND = 3'd1;
  localparam logic [2:0] OP_KILL    = 3'd2;
  localparam logic [2:0] OP_LOOKUP  = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  // Internal code for an operation that has no effect on the list.
  localparam logic [2:0] OP_NONE    = 3'd7;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_FG    = 2'd1;
  localparam logic [1:0] ST_BG    = 2'd2;

endpackage

>>> src/mal_ram.sv
// ----------------------------------------------------------------------------
// mal_ram: list entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mal_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mal_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output mal_pkg::entry_t rdata
);
  import mal_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/mru_app_list.sv
// ----------------------------------------------------------------------------
// mru_app_list: most-recent-first list of application keys
// Launch, suspend, kill, lookup and read on a list held in a small memory.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. A single key
// comparator walks the list one entry per cycle through the memory's read
// port, moving entries as it goes, for launch, suspend, kill and lookup;
// read and operations with no effect go straight to the finishing state.
// busy stays high from acceptance through the finishing state.
// Each result appears on the out_ ports for exactly one cycle, marked by
// out_valid, and must be taken then: there is no way to hold it off.
module mru_app_list #(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_app_key,
  input  logic [2:0] in_slot_index,
  output logic       out_valid,
  output logic       out_hit,
  output logic [3:0] out_entry_count,
  output logic [7:0] out_entry_key,
  output logic [1:0] out_entry_state
);
  import mal_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = CW + 3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_END  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [7:0]    key_r, key_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  entry_t        carry_r, carry_nxt;
  logic          hit_r, hit_nxt;
  logic          found_r, found_nxt;
  logic          rd_ok_r, rd_ok_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [3:0]    out_count_r, out_count_nxt;
  logic [7:0]    out_key_r, out_key_nxt;
  logic [1:0]    out_state_r, out_state_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  logic          accept, match, last, stop, scan_op;
  logic [CW-1:0] idx_inc, idx_dec;
  logic [IW-1:0] slot_w, cnt_w;
  logic [CW+3:0] cnt_ext;
  logic [2:0]    op_eff;

  mal_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept  = start && (state_r == S_IDLE);
  assign match   = (rdata.key == key_r);
  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);
  assign last    = (idx_inc == cnt_r);
  assign slot_w  = {{CW{1'b0}}, in_slot_index};
  assign cnt_w   = {3'b000, cnt_r};
  assign cnt_ext = {4'b0000, cnt_nxt};

  // A null key turns launch, kill and lookup into an operation with no effect.
  always_comb begin
    op_eff = in_operation;
    if ((in_app_key == 8'd0) &&
        ((in_operation == OP_LAUNCH) || (in_operation == OP_KILL) ||
         (in_operation == OP_LOOKUP))) begin
      op_eff = OP_NONE;
    end
    scan_op = (op_eff == OP_LAUNCH) || (op_eff == OP_SUSPEND) ||
              (op_eff == OP_KILL) || (op_eff == OP_LOOKUP);
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    carry_nxt     = carry_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_count_nxt = out_count_r;
    out_key_nxt   = out_key_r;
    out_state_nxt = out_state_r;
    we            = 1'b0;
    waddr         = idx_r[AW-1:0];
    wdata         = carry_r;
    re            = 1'b0;
    raddr         = '0;
    stop          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = op_eff;
          key_nxt   = in_app_key;
          idx_nxt   = '0;
          carry_nxt = '{fg: 1'b1, key: in_app_key};
          hit_nxt   = 1'b0;
          found_nxt = 1'b0;
          rd_ok_nxt = (op_eff == OP_READ) && (slot_w < cnt_w);
          if (scan_op && (cnt_r != '0)) begin
            re        = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            re        = (op_eff == OP_READ) && (slot_w < cnt_w);
            raddr     = slot_w[AW-1:0];
            state_nxt = S_END;
          end
        end
      end

      S_SCAN: begin
        // rdata holds the entry at idx_r.
        unique case (op_r)
          OP_LAUNCH: begin
            // Write the carried entry here and carry the old one onward; a
            // match ends the shift since its own slot has been filled.
            we        = 1'b1;
            carry_nxt = rdata;
            if (match) begin
              hit_nxt = 1'b1;
              stop    = 1'b1;
            end
          end
          OP_SUSPEND: begin
            if (rdata.fg) begin
              we      = 1'b1;
              wdata   = '{fg: 1'b0, key: rdata.key};
              hit_nxt = 1'b1;
              stop    = 1'b1;
            end
          end
          OP_KILL: begin
            // Once the key has been seen, each later entry moves up a place.
            if (found_r) begin
              we    = 1'b1;
              waddr = idx_dec[AW-1:0];
              wdata = rdata;
            end else if (match) begin
              found_nxt = 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (match) begin
              hit_nxt = 1'b1;
              stop    = 1'b1;
            end
          end
          default: begin
            stop = 1'b1;
          end
        endcase
        if (stop || last) begin
          state_nxt = S_END;
        end else begin
          idx_nxt = idx_inc;
          re      = 1'b1;
          raddr   = idx_inc[AW-1:0];
        end
      end

      S_END: begin
        if ((op_r == OP_LAUNCH) && !hit_r && (cnt_r < CW'(DEPTH))) begin
          we      = 1'b1;
          waddr   = cnt_r[AW-1:0];
          wdata   = carry_r;
          cnt_nxt = cnt_r + CW'(1);
        end else if ((op_r == OP_KILL) && found_r) begin
          cnt_nxt = cnt_r - CW'(1);
        end
        out_valid_nxt = 1'b1;
        out_hit_nxt   = hit_r || ((op_r == OP_KILL) && found_r);
        out_count_nxt = cnt_ext[3:0];
        if (rd_ok_r) begin
          out_key_nxt   = rdata.key;
          out_state_nxt = rdata.fg ? ST_FG : ST_BG;
        end else begin
          out_key_nxt   = 8'd0;
          out_state_nxt = ST_EMPTY;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    carry_r     <= carry_nxt;
    hit_r       <= hit_nxt;
    found_r     <= found_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_hit_r   <= out_hit_nxt;
    out_count_r <= out_count_nxt;
    out_key_r   <= out_key_nxt;
    out_state_r <= out_state_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_entry_count = out_count_r;
  assign out_entry_key   = out_key_r;
  assign out_entry_state = out_state_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds list depth");

  a_scan_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r < cnt_r))
    else $error("scan index beyond the filled part of the list");

  a_result_after_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_END) && (state_r == S_IDLE))
    else $error("result beat without a finishing step");

  a_one_per_item : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END) |=> !busy)
    else $error("block still busy after a result");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the most-recent-first application list
// Drives launch, suspend, kill, lookup, read and spare command codes into
// mru_app_list, mirrors the list in a scoreboard and compares every reply.
// ----------------------------------------------------------------------------
module tb_top;
  import mal_pkg::*;

  localparam int LIST_DEPTH = 8;
  localparam int PHASE_CMDS = 300;
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;

  typedef struct {
    logic       hit;
    logic [3:0] count;
    logic [7:0] key;
    logic [1:0] state;
  } list_reply_t;

  // Mirror of the list contents plus the queue of replies still to come.
  class mru_tracker;
    entry_t      slots[LIST_DEPTH];
    int unsigned used;
    list_reply_t reply_q[$];
    int unsigned errors, cmds, replies, hits, drops;

    function int find_key(logic [7:0] key);
      for (int i = 0; i < used; i++)
        if (slots[i].key == key) return i;
      return -1;
    endfunction

    // Entries ahead of pos slide back one place; the key goes in at the front.
    function void to_front(int unsigned pos, logic [7:0] key);
      for (int j = pos; j > 0; j--) slots[j] = slots[j-1];
      slots[0].key = key;
      slots[0].fg  = 1'b1;
    endfunction

    function void take_cmd(logic [2:0] op, logic [7:0] key, logic [2:0] idx);
      list_reply_t r;
      int          pos;
      r = '{hit: 1'b0, count: 4'd0, key: 8'd0, state: ST_EMPTY};
      cmds++;
      case (op)
        OP_LAUNCH: begin
          if (key != 8'd0) begin
            pos = find_key(key);
            if (pos >= 0) begin
              r.hit = 1'b1;
              to_front(pos, key);
            end else if (used < LIST_DEPTH) begin
              to_front(used, key);
              used++;
            end else begin
              to_front(LIST_DEPTH - 1, key);
              drops++;
            end
          end
        end
        OP_SUSPEND: begin
          for (int i = 0; i < used; i++) begin
            if (slots[i].fg) begin
              slots[i].fg = 1'b0;
              r.hit = 1'b1;
              break;
            end
          end
        end
        OP_KILL: begin
          if (key != 8'd0) begin
            pos = find_key(key);
            if (pos >= 0) begin
              r.hit = 1'b1;
              for (int i = pos; i + 1 < used; i++) slots[i] = slots[i+1];
              used--;
            end
          end
        end
        OP_LOOKUP: r.hit = (key != 8'd0) && (find_key(key) >= 0);
        OP_READ: begin
          if (idx < used) begin
            r.key   = slots[idx].key;
            r.state = slots[idx].fg ? ST_FG : ST_BG;
          end
        end
        default: ;
      endcase
      r.count = used[3:0];
      reply_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic hit, logic [3:0] count, logic [7:0] key, logic [1:0] state);
      list_reply_t r;
      replies++;
      if (reply_q.size() == 0) begin
        report("reply beat with no command outstanding");
      end else begin
        r = reply_q.pop_front();
        if (hit === 1'b1) hits++;
        if (hit !== r.hit)
          report($sformatf("hit %b, expected %b", hit, r.hit));
        if (count !== r.count)
          report($sformatf("entry_count %0d, expected %0d", count, r.count));
        if (key !== r.key)
          report($sformatf("entry_key %0d, expected %0d", key, r.key));
        if (state !== r.state)
          report($sformatf("entry_state %0d, expected %0d", state, r.state));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_operation = OP_READ;
  logic [7:0] in_app_key = 8'd0;
  logic [2:0] in_slot_index = 3'd0;
  logic       out_valid;
  logic       out_hit;
  logic [3:0] out_entry_count;
  logic [7:0] out_entry_key;
  logic [1:0] out_entry_state;

  mru_tracker  tracker = new();
  logic [7:0]  key_pool[12];
  int unsigned n_directed;

  mru_app_list #(.DEPTH(LIST_DEPTH)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_app_key      (in_app_key),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_entry_count (out_entry_count),
    .out_entry_key   (out_entry_key),
    .out_entry_state (out_entry_state)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The reply is checked before the new command is noted, since a reply can
  // never belong to a command taken on the same edge.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_result(out_hit, out_entry_count, out_entry_key, out_entry_state);
    if (rst_n && start && !busy)
      tracker.take_cmd(in_operation, in_app_key, in_slot_index);
  end

  task automatic send(logic [2:0] op, logic [7:0] key, logic [2:0] idx);
    @(negedge clk);
    start = 1'b1;
    in_operation = op;
    in_app_key = key;
    in_slot_index = idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic gap(int unsigned cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Hold off until every reply owed has arrived.
  task automatic drain();
    gap(1);
    while (tracker.reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  key;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_LAUNCH;
    else if (pick < 50) op = OP_SUSPEND;
    else if (pick < 65) op = OP_KILL;
    else if (pick < 80) op = OP_LOOKUP;
    else if (pick < 95) op = OP_READ;
    else                op = 3'($urandom_range(OP_SPARE_A, OP_NONE));
    // Mostly keys from a small pool so that hits and moves are common.
    if ($urandom_range(0, 3) != 0) key = key_pool[$urandom_range(0, 11)];
    else                           key = 8'($urandom_range(0, 255));
    send(op, key, 3'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Everything on an empty list, then the null key.
    send(OP_READ, 8'd0, 3'd0);
    send(OP_SUSPEND, 8'd0, 3'd0);
    send(OP_LOOKUP, 8'h55, 3'd0);
    send(OP_KILL, 8'h55, 3'd0);
    send(OP_LAUNCH, 8'd0, 3'd7);
    // Fill the list, overflow it, then move an entry from the middle.
    foreach (key_pool[i]) key_pool[i] = 8'd0;
    send(OP_LAUNCH, 8'hFF, 3'd0);
    send(OP_LAUNCH, 8'h01, 3'd0);
    send(OP_LAUNCH, 8'h80, 3'd0);
    send(OP_LAUNCH, 8'h7F, 3'd0);
    send(OP_LAUNCH, 8'hAA, 3'd0);
    send(OP_LAUNCH, 8'h55, 3'd0);
    send(OP_LAUNCH, 8'h10, 3'd0);
    send(OP_LAUNCH, 8'h20, 3'd0);
    send(OP_LAUNCH, 8'h33, 3'd0);
    send(OP_LAUNCH, 8'h80, 3'd0);
    send(OP_LOOKUP, 8'h01, 3'd0);
    send(OP_LOOKUP, 8'd0, 3'd0);
    send(OP_KILL, 8'd0, 3'd0);
    send(OP_SUSPEND, 8'd0, 3'd0);
    send(OP_READ, 8'd0, 3'd7);
    send(OP_READ, 8'd0, 3'd0);
    send(OP_KILL, 8'h01, 3'd0);
    send(OP_KILL, 8'h55, 3'd0);
    send(OP_READ, 8'd0, 3'd7);
    send(OP_SPARE_A, 8'hFF, 3'd7);
    send(OP_SPARE_B, 8'h00, 3'd0);
    send(OP_NONE, 8'hFF, 3'd7);
    n_directed = tracker.cmds;
    drain();

    // The last phase runs without any idle beats.
    for (int phase = 0; phase < 3; phase++) begin
      foreach (key_pool[i]) key_pool[i] = 8'($urandom_range(1, 255));
      repeat (PHASE_CMDS) begin
        send_random();
        if (phase < 2 && $urandom_range(0, 5) == 0) gap($urandom_range(1, 14));
      end
      drain();
    end

    repeat (LIST_DEPTH + 4) @(posedge clk);
    if (tracker.reply_q.size() != 0)
      tracker.report($sformatf("%0d replies never arrived", tracker.reply_q.size()));
    $display("Covered %0d commands (%0d directed) and %0d reply beats, %0d with hit set,",
             tracker.cmds, n_directed, tracker.replies, tracker.hits);
    $display("including %0d launches that pushed the oldest entry off a full list.",
             tracker.drops);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
